>>> rtl/bwfa_pkg.sv
// ----------------------------------------------------------------------------
// bwfa_pkg
// Types, codes and defaults shared by the segment allocator modules.
// ----------------------------------------------------------------------------
package bwfa_pkg;

  localparam int DEF_FREE_ENTRIES  = 64;
  localparam int DEF_ALLOC_ENTRIES = 64;
  localparam int DEF_ADDR_BITS     = 20;
  localparam int DEF_HEADER_BYTES  = 8;
  localparam int DEF_NODE_BYTES    = 16;

  localparam int SIZE_BITS   = 20;
  localparam int OFFSET_BITS = 20;
  localparam int REGION_BITS = 21;
  localparam int REGION_RESET = 65536;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic CFG_FIT_POLICY   = 1'b0;
  localparam logic CFG_REGION_BYTES = 1'b1;

  localparam logic POLICY_BEST  = 1'b0;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_NULL      = 3'd3,
    ST_NOT_ALLOC = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC_SCAN,
    S_BLOCK_SCAN,
    S_SEG_SCAN
  } state_t;

  typedef struct packed {
    cmd_e_t                 cmd;
    logic [SIZE_BITS-1:0]   req_size;
    logic [OFFSET_BITS-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] addr;
    status_t                status;
  } result_t;

  // classified request as it waits between front and back
  typedef struct packed {
    req_t    req;
    status_t pre;
  } queue_item_t;

endpackage

>>> rtl/best_worst_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// best_worst_fit_segment_allocator
// Best/worst fit free-segment allocator with a request queue and table scan.
// ----------------------------------------------------------------------------
// A request rejected up front is reported as soon as the back end pops it; an
//   alloc scans the free and allocation tables side by side, and a free scans
//   the allocation table and then the free table, each scan one entry a cycle
//   with one extra step to drain the RAM read pipeline.
// Throughput: one request at a time in the scan unit; a 2-entry queue holds
//   further requests, and busy is high while it is full. Results cannot stall.
// Reset: policy best fit, region 65536 bytes, one free segment, no blocks.
module best_worst_fit_segment_allocator #(
  parameter int FREE_ENTRIES  = bwfa_pkg::DEF_FREE_ENTRIES,
  parameter int ALLOC_ENTRIES = bwfa_pkg::DEF_ALLOC_ENTRIES,
  parameter int ADDR_BITS     = bwfa_pkg::DEF_ADDR_BITS,
  parameter int HEADER_BYTES  = bwfa_pkg::DEF_HEADER_BYTES,
  parameter int NODE_BYTES    = bwfa_pkg::DEF_NODE_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  bwfa_pkg::req_t                      req,
  output logic                                done,
  output bwfa_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [bwfa_pkg::REGION_BITS-1:0]    cfg_data
);
  import bwfa_pkg::*;

  localparam int W = ((ADDR_BITS > OFFSET_BITS) ? ADDR_BITS : OFFSET_BITS) + 1;

  logic         fit_policy;
  logic [W-1:0] usable;
  logic         reinit;
  logic         q_valid, q_pop;
  queue_item_t  q_item;

  // clamp the region to the address space and take off the node overhead
  function automatic logic [W-1:0] usable_of(input logic [REGION_BITS-1:0] region);
    logic [33:0] r;
    logic [33:0] lim;
    lim = 34'(1) << ADDR_BITS;
    r   = 34'(region);
    if (r > lim) r = lim;
    return (r > 34'(NODE_BYTES)) ? W'(r - 34'(NODE_BYTES)) : '0;
  endfunction

  assign reinit = cfg_we && (cfg_index == CFG_REGION_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POLICY_BEST;
      usable     <= usable_of(REGION_BITS'(REGION_RESET));
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_POLICY:   fit_policy <= cfg_data[0];
        CFG_REGION_BYTES: usable     <= usable_of(cfg_data);
        default:          fit_policy <= fit_policy;
      endcase
    end
  end

  bwfa_front #(
    .ADDR_BITS(ADDR_BITS), .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk, .rst, .start, .busy, .req, .usable,
    .q_valid, .q_item, .q_pop
  );

  bwfa_back #(
    .FREE_ENTRIES(FREE_ENTRIES), .ALLOC_ENTRIES(ALLOC_ENTRIES),
    .ADDR_BITS(ADDR_BITS), .HEADER_BYTES(HEADER_BYTES)
  ) u_back (
    .clk, .rst, .reinit, .fit_policy, .usable,
    .q_valid, .q_item, .q_pop, .done, .result
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_early_reject: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_item.pre != ST_OK |=> done && result.status == $past(q_item.pre))
    else $error("pre-classified reject not reported next cycle");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_OK |-> result.addr == '0)
    else $error("failed request carries an address");

endmodule

>>> rtl/bwfa_ram.sv
// ----------------------------------------------------------------------------
// bwfa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bwfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bwfa_front.sv
// ----------------------------------------------------------------------------
// bwfa_front
// Accepts requests, flags oversized allocs and null frees, and queues them.
// ----------------------------------------------------------------------------
module bwfa_front #(
  parameter int ADDR_BITS    = bwfa_pkg::DEF_ADDR_BITS,
  parameter int HEADER_BYTES = bwfa_pkg::DEF_HEADER_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  bwfa_pkg::req_t        req,
  input  logic [((ADDR_BITS > bwfa_pkg::OFFSET_BITS) ? ADDR_BITS
                 : bwfa_pkg::OFFSET_BITS):0] usable,
  output logic                  q_valid,
  output bwfa_pkg::queue_item_t q_item,
  input  logic                  q_pop
);
  import bwfa_pkg::*;

  localparam int W  = ((ADDR_BITS > OFFSET_BITS) ? ADDR_BITS : OFFSET_BITS) + 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  queue_item_t      entry [QUEUE_DEPTH];
  queue_item_t      item_in;
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;
  logic             too_large;

  assign too_large = ((W+1)'(req.req_size) + (W+1)'(HEADER_BYTES)) > (W+1)'(usable);

  always_comb begin
    item_in.req = req;
    item_in.pre = ST_OK;
    if (req.cmd == CMD_ALLOC) begin
      if (too_large) item_in.pre = ST_TOO_LARGE;
    end else begin
      if (req.free_addr == '0) item_in.pre = ST_NULL;
    end
  end

  assign busy    = (count == CW'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/bwfa_back.sv
// ----------------------------------------------------------------------------
// bwfa_back
// Scans the free and allocation tables for each queued request that was not
// rejected up front, and commits the split or merge in the cycle the scan ends.
// ----------------------------------------------------------------------------
module bwfa_back #(
  parameter int FREE_ENTRIES  = bwfa_pkg::DEF_FREE_ENTRIES,
  parameter int ALLOC_ENTRIES = bwfa_pkg::DEF_ALLOC_ENTRIES,
  parameter int ADDR_BITS     = bwfa_pkg::DEF_ADDR_BITS,
  parameter int HEADER_BYTES  = bwfa_pkg::DEF_HEADER_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  reinit,
  input  logic                  fit_policy,
  input  logic [((ADDR_BITS > bwfa_pkg::OFFSET_BITS) ? ADDR_BITS
                 : bwfa_pkg::OFFSET_BITS):0] usable,
  input  logic                  q_valid,
  input  bwfa_pkg::queue_item_t q_item,
  output logic                  q_pop,
  output logic                  done,
  output bwfa_pkg::result_t     result
);
  import bwfa_pkg::*;

  localparam int W    = ((ADDR_BITS > OFFSET_BITS) ? ADDR_BITS : OFFSET_BITS) + 1;
  localparam int FI   = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int AI   = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
  localparam int MAXE = (FREE_ENTRIES > ALLOC_ENTRIES) ? FREE_ENTRIES : ALLOC_ENTRIES;
  localparam int CW   = $clog2(MAXE + 1);

  state_t state, state_next;

  logic [CW-1:0] cnt, idx_d, limit;
  logic          pend, scan_done;

  logic [W-1:0]  item_size, item_offset;

  logic          pick_found;
  logic [FI-1:0] pick_idx;
  logic [W-1:0]  pick_diff, pick_start, pick_len;
  logic          slot_found;
  logic [AI-1:0] slot_idx;

  logic          blk_found;
  logic [AI-1:0] blk_idx;
  logic [W-1:0]  blk_start, blk_len;
  logic          pred_found, succ_found, fslot_found;
  logic [FI-1:0] pred_idx, succ_idx, fslot_idx;
  logic [W-1:0]  pred_start, pred_len, succ_len;

  logic          seg_valid [FREE_ENTRIES];
  logic          blk_valid [ALLOC_ENTRIES];
  logic          seg0_init;

  logic [2*W-1:0] seg_rdata, blk_rdata, seg_wdata, blk_wdata;
  logic           seg_we, blk_we;
  logic [FI-1:0]  seg_waddr;
  logic [AI-1:0]  blk_waddr;
  logic [W-1:0]   e_start, e_len, b_start, b_len;
  logic [W-1:0]   need, diff, lo, hi, span;
  logic [FI-1:0]  e_idx;
  logic [AI-1:0]  b_idx;
  logic           e_in, b_in, take;

  logic           sv_en, sv_val, sv_clr_en, bv_en, bv_val;
  logic [FI-1:0]  sv_idx, sv_clr_idx;
  logic [AI-1:0]  bv_idx;
  logic           done_next;
  result_t        result_next;

  bwfa_ram #(.WIDTH(2*W), .DEPTH(FREE_ENTRIES)) u_seg_ram (
    .clk, .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(cnt[FI-1:0]), .rdata(seg_rdata)
  );

  bwfa_ram #(.WIDTH(2*W), .DEPTH(ALLOC_ENTRIES)) u_blk_ram (
    .clk, .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
    .raddr(cnt[AI-1:0]), .rdata(blk_rdata)
  );

  // entry 0 reads as the whole usable region until it is first written
  assign e_idx   = idx_d[FI-1:0];
  assign b_idx   = idx_d[AI-1:0];
  assign e_in    = pend && (idx_d < CW'(FREE_ENTRIES));
  assign b_in    = pend && (idx_d < CW'(ALLOC_ENTRIES));
  assign e_start = (seg0_init && e_idx == '0) ? '0 : seg_rdata[2*W-1:W];
  assign e_len   = (seg0_init && e_idx == '0) ? usable : seg_rdata[W-1:0];
  assign b_start = blk_rdata[2*W-1:W];
  assign b_len   = blk_rdata[W-1:0];

  assign need = item_size + W'(HEADER_BYTES);
  assign diff = e_len - need;
  assign lo   = blk_start - W'(HEADER_BYTES);
  assign hi   = blk_start + blk_len;
  assign span = hi - lo;

  always_comb begin
    if (!pick_found) take = 1'b1;
    else if (diff == pick_diff) take = e_start < pick_start;
    else if (fit_policy == POLICY_BEST) take = diff < pick_diff;
    else take = diff > pick_diff;
  end

  always_comb begin
    unique case (state)
      S_ALLOC_SCAN: limit = CW'(MAXE);
      S_BLOCK_SCAN: limit = CW'(ALLOC_ENTRIES);
      S_SEG_SCAN:   limit = CW'(FREE_ENTRIES);
      default:      limit = '0;
    endcase
  end
  assign scan_done = (cnt == limit) && !pend;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    done_next   = 1'b0;
    result_next = '{addr: '0, status: ST_OK};
    seg_we = 1'b0; seg_waddr = '0; seg_wdata = '0;
    blk_we = 1'b0; blk_waddr = '0; blk_wdata = '0;
    sv_en = 1'b0; sv_idx = '0; sv_val = 1'b0;
    sv_clr_en = 1'b0; sv_clr_idx = '0;
    bv_en = 1'b0; bv_idx = '0; bv_val = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.pre != ST_OK) begin
            done_next = 1'b1;
            result_next.status = q_item.pre;
          end else if (q_item.req.cmd == CMD_FREE) begin
            state_next = S_BLOCK_SCAN;
          end else begin
            state_next = S_ALLOC_SCAN;
          end
        end
      end
      S_ALLOC_SCAN: begin
        if (scan_done) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (!pick_found) begin
            result_next.status = ST_NO_FIT;
          end else if (!slot_found) begin
            result_next.status = ST_FULL;
          end else begin
            blk_we    = 1'b1;
            blk_waddr = slot_idx;
            blk_wdata = {pick_start + W'(HEADER_BYTES), item_size};
            bv_en = 1'b1; bv_idx = slot_idx; bv_val = 1'b1;
            seg_we    = 1'b1;
            seg_waddr = pick_idx;
            seg_wdata = {pick_start + need, pick_len - need};
            sv_en = 1'b1; sv_idx = pick_idx; sv_val = (pick_len != need);
            result_next.addr = OFFSET_BITS'(pick_start + W'(HEADER_BYTES));
          end
        end
      end
      S_BLOCK_SCAN: begin
        if (scan_done) begin
          if (blk_found) begin
            state_next = S_SEG_SCAN;
          end else begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            result_next.status = ST_NOT_ALLOC;
          end
        end
      end
      S_SEG_SCAN: begin
        if (scan_done) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          bv_en = 1'b1; bv_idx = blk_idx; bv_val = 1'b0;
          priority if (pred_found && succ_found) begin
            seg_we = 1'b1; seg_waddr = pred_idx;
            seg_wdata = {pred_start, pred_len + span + succ_len};
            sv_clr_en = 1'b1; sv_clr_idx = succ_idx;
          end else if (pred_found) begin
            seg_we = 1'b1; seg_waddr = pred_idx;
            seg_wdata = {pred_start, pred_len + span};
          end else if (succ_found) begin
            seg_we = 1'b1; seg_waddr = succ_idx;
            seg_wdata = {lo, succ_len + span};
          end else if (span != '0) begin
            if (fslot_found) begin
              seg_we = 1'b1; seg_waddr = fslot_idx;
              seg_wdata = {lo, span};
              sv_en = 1'b1; sv_idx = fslot_idx; sv_val = 1'b1;
            end else begin
              bv_en = 1'b0;
              result_next.status = ST_FULL;
            end
          end else begin
            // empty span touching nothing: just release the block
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // scan counter and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (state == S_IDLE || scan_done) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (cnt != limit) begin
      cnt  <= cnt + 1'b1;
      pend <= 1'b1;
    end else begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= cnt;
    if (state == S_IDLE) begin
      item_size     <= W'(q_item.req.req_size);
      item_offset   <= W'(q_item.req.free_addr);
      pick_found    <= 1'b0;
      slot_found    <= 1'b0;
      blk_found     <= 1'b0;
    end
    if (state == S_BLOCK_SCAN) begin
      pred_found  <= 1'b0;
      succ_found  <= 1'b0;
      fslot_found <= 1'b0;
    end
    if (state == S_ALLOC_SCAN) begin
      if (e_in && seg_valid[e_idx] && e_len >= need && take) begin
        pick_found <= 1'b1;
        pick_idx   <= e_idx;
        pick_diff  <= diff;
        pick_start <= e_start;
        pick_len   <= e_len;
      end
      if (b_in && !slot_found && !blk_valid[b_idx]) begin
        slot_found <= 1'b1;
        slot_idx   <= b_idx;
      end
    end
    if (state == S_BLOCK_SCAN && b_in && !blk_found && blk_valid[b_idx]
        && b_start == item_offset) begin
      blk_found <= 1'b1;
      blk_idx   <= b_idx;
      blk_start <= b_start;
      blk_len   <= b_len;
    end
    if (state == S_SEG_SCAN && e_in) begin
      if (seg_valid[e_idx]) begin
        if (!pred_found && ((W+1)'(e_start) + (W+1)'(e_len)) == (W+1)'(lo)) begin
          pred_found <= 1'b1;
          pred_idx   <= e_idx;
          pred_start <= e_start;
          pred_len   <= e_len;
        end else if (!succ_found && e_start == hi) begin
          succ_found <= 1'b1;
          succ_idx   <= e_idx;
          succ_len   <= e_len;
        end
      end else if (!fslot_found) begin
        fslot_found <= 1'b1;
        fslot_idx   <= e_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || reinit) begin
      for (int i = 0; i < FREE_ENTRIES; i++) seg_valid[i] <= (i == 0);
      for (int i = 0; i < ALLOC_ENTRIES; i++) blk_valid[i] <= 1'b0;
      seg0_init <= 1'b1;
    end else begin
      if (sv_clr_en) seg_valid[sv_clr_idx] <= 1'b0;
      if (sv_en) seg_valid[sv_idx] <= sv_val;
      if (bv_en) blk_valid[bv_idx] <= bv_val;
      if (seg_we && seg_waddr == '0) seg0_init <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= done_next;
    result <= result_next;
  end

endmodule

>>> dv/bwfa_checker.sv
// ----------------------------------------------------------------------------
// bwfa_checker
// Watches the request, result and register ports of the segment allocator,
// keeps its own free and allocation tables, and compares every result.
// ----------------------------------------------------------------------------
module bwfa_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  bwfa_pkg::req_t                   req,
  input  logic                             done,
  input  bwfa_pkg::result_t                result,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [bwfa_pkg::REGION_BITS-1:0] cfg_data,
  output int                               errors,
  output int                               pending,
  output int                               ok_count,
  output int                               reject_count
);
  import bwfa_pkg::*;

  localparam int NF  = DEF_FREE_ENTRIES;
  localparam int NA  = DEF_ALLOC_ENTRIES;
  localparam int HDR = DEF_HEADER_BYTES;
  localparam int NOD = DEF_NODE_BYTES;

  logic              policy;
  longint            region;
  longint            usable;
  longint            fseg_start [NF];
  longint            fseg_len   [NF];
  bit                fseg_on    [NF];
  longint            blk_start  [NA];
  longint            blk_len    [NA];
  bit                blk_on     [NA];
  result_t           expected_results [$];

  task automatic rebuild_tables();
    longint r;
    r = region;
    if (r > (longint'(1) << DEF_ADDR_BITS)) r = longint'(1) << DEF_ADDR_BITS;
    usable = (r > NOD) ? r - NOD : 0;
    for (int i = 0; i < NF; i++) begin
      fseg_start[i] = 0; fseg_len[i] = 0; fseg_on[i] = 0;
    end
    for (int i = 0; i < NA; i++) begin
      blk_start[i] = 0; blk_len[i] = 0; blk_on[i] = 0;
    end
    fseg_len[0] = usable;
    fseg_on[0]  = 1;
  endtask

  task automatic predict_alloc(input longint size, output status_t st, output longint a);
    longint need, diff, pick_diff;
    int pick, slot;
    bit take;
    need = size + HDR; pick = -1; slot = -1; pick_diff = 0; a = 0;
    if (size > usable - HDR) begin
      st = ST_TOO_LARGE; return;
    end
    for (int i = 0; i < NF; i++) begin
      if (fseg_on[i] && fseg_len[i] >= need) begin
        diff = fseg_len[i] - need;
        if (pick < 0) take = 1;
        else if (diff == pick_diff) take = fseg_start[i] < fseg_start[pick];
        else if (policy == POLICY_BEST) take = diff < pick_diff;
        else take = diff > pick_diff;
        if (take) begin
          pick = i; pick_diff = diff;
        end
      end
    end
    if (pick < 0) begin
      st = ST_NO_FIT; return;
    end
    for (int i = 0; i < NA; i++)
      if (!blk_on[i] && slot < 0) slot = i;
    if (slot < 0) begin
      st = ST_FULL; return;
    end
    blk_start[slot] = fseg_start[pick] + HDR;
    blk_len[slot]   = size;
    blk_on[slot]    = 1;
    a = blk_start[slot];
    fseg_start[pick] += need;
    fseg_len[pick]   -= need;
    if (fseg_len[pick] == 0) fseg_on[pick] = 0;
    st = ST_OK;
  endtask

  task automatic predict_free(input longint off, output status_t st);
    int blk, pred, succ, slot;
    longint lo, hi, span;
    blk = -1; pred = -1; succ = -1; slot = -1;
    if (off == 0) begin
      st = ST_NULL; return;
    end
    for (int i = 0; i < NA; i++)
      if (blk < 0 && blk_on[i] && blk_start[i] == off) blk = i;
    if (blk < 0) begin
      st = ST_NOT_ALLOC; return;
    end
    lo = blk_start[blk] - HDR;
    hi = blk_start[blk] + blk_len[blk];
    span = hi - lo;
    for (int i = 0; i < NF; i++) begin
      if (fseg_on[i]) begin
        if (pred < 0 && fseg_start[i] + fseg_len[i] == lo) pred = i;
        else if (succ < 0 && fseg_start[i] == hi) succ = i;
      end
    end
    if (pred >= 0 && succ >= 0) begin
      fseg_len[pred] += span + fseg_len[succ];
      fseg_on[succ] = 0;
    end else if (pred >= 0) begin
      fseg_len[pred] += span;
    end else if (succ >= 0) begin
      fseg_start[succ] = lo;
      fseg_len[succ] += span;
    end else if (span != 0) begin
      for (int i = 0; i < NF; i++)
        if (!fseg_on[i] && slot < 0) slot = i;
      if (slot < 0) begin
        st = ST_FULL; return;
      end
      fseg_start[slot] = lo; fseg_len[slot] = span; fseg_on[slot] = 1;
    end
    blk_on[blk] = 0;
    st = ST_OK;
  endtask

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    status_t st;
    longint  a;
    if (rst) begin
      policy = POLICY_BEST;
      region = REGION_RESET;
      rebuild_tables();
      expected_results.delete();
      errors = 0; ok_count = 0; reject_count = 0;
      pending = 0;
    end else begin
      // results of this edge are compared before a new transfer is predicted
      if (done) begin
        if (expected_results.size() == 0) begin
          report("unexpected result, status", int'(result.status), 0);
        end else begin
          exp_r = expected_results.pop_front();
          if (result.addr !== exp_r.addr)
            report("addr", int'(result.addr), int'(exp_r.addr));
          if (result.status !== exp_r.status)
            report("status", int'(result.status), int'(exp_r.status));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_FIT_POLICY) policy = cfg_data[0];
        else begin
          region = longint'(cfg_data);
          rebuild_tables();
        end
      end
      if (start && !busy) begin
        if (req.cmd == CMD_ALLOC) predict_alloc(longint'(req.req_size), st, a);
        else begin
          predict_free(longint'(req.free_addr), st);
          a = 0;
        end
        if (st == ST_OK) ok_count++; else reject_count++;
        exp_r.addr   = a[OFFSET_BITS-1:0];
        exp_r.status = st;
        expected_results.push_back(exp_r);
      end
      pending = expected_results.size();
    end
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free requests into the segment allocator under several
// policy and region settings; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module testbench;
  import bwfa_pkg::*;

  localparam longint CYCLE_LIMIT = 400000;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  req_t                   req;
  logic                   done;
  result_t                result;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [REGION_BITS-1:0] cfg_data;
  int                     errors;
  int                     pending;
  int                     ok_count;
  int                     reject_count;
  longint                 cycles;
  logic [OFFSET_BITS-1:0] granted [$];
  int                     sent;
  bit                     quiet;

  best_worst_fit_segment_allocator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bwfa_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .ok_count(ok_count),
    .reject_count(reject_count)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // watch granted offsets so frees mostly hit live blocks
  always @(posedge clk)
    if (!rst && done && result.status == ST_OK && result.addr != 0)
      granted.push_back(result.addr);

  task automatic send(input cmd_e_t c, input int size, input int off);
    if (!quiet)
      while ($urandom_range(99) < 6) @(negedge clk);
    req.cmd = c;
    req.req_size = SIZE_BITS'(size);
    req.free_addr = OFFSET_BITS'(off);
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (160) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    drain();
    cfg_we = 1; cfg_index = idx; cfg_data = REGION_BITS'(val);
    @(negedge clk);
    cfg_we = 0;
    if (idx == CFG_REGION_BYTES) granted.delete();
  endtask

  task automatic random_free();
    int k;
    if (granted.size() != 0 && $urandom_range(9) < 8) begin
      k = $urandom_range(granted.size() - 1);
      send(CMD_FREE, int'($urandom), int'(granted[k]));
      granted.delete(k);
    end else begin
      send(CMD_FREE, int'($urandom), $urandom_range(3) == 0 ? 0 : int'($urandom));
    end
  endtask

  task automatic random_phase(input int n, input int size_cap);
    for (int i = 0; i < n; i++) begin
      quiet = (i >= n / 3 && i < n / 2);
      if ($urandom_range(99) < 3) send(CMD_ALLOC, int'($urandom), 0);
      else if ($urandom_range(1)) send(CMD_ALLOC, int'($urandom_range(size_cap)), 0);
      else random_free();
      if (i == n / 2) drain();
    end
    quiet = 0;
  endtask

  initial begin
    rst = 1; start = 0; req = '0; cfg_we = 0; cfg_index = CFG_FIT_POLICY; cfg_data = '0;
    sent = 0; quiet = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed: extremes, rejects, exact fit, double free
    send(CMD_ALLOC, 0, 0);
    send(CMD_ALLOC, 20'hFFFFF, 0);
    send(CMD_ALLOC, 65536 - 16 - 8, 0);
    send(CMD_ALLOC, 65536 - 16 - 7, 0);
    send(CMD_FREE, 0, 0);
    send(CMD_FREE, 0, 20'hFFFFF);
    send(CMD_FREE, 0, 8);
    send(CMD_FREE, 0, 8);
    drain();
    write_reg(CFG_REGION_BYTES, 64);
    send(CMD_ALLOC, 40, 0);
    send(CMD_ALLOC, 41, 0);
    send(CMD_ALLOC, 8, 0);
    send(CMD_ALLOC, 8, 0);
    send(CMD_ALLOC, 8, 0);
    send(CMD_ALLOC, 0, 0);
    send(CMD_FREE, 0, 24);
    send(CMD_FREE, 0, 8);
    send(CMD_FREE, 0, 40);
    write_reg(CFG_REGION_BYTES, 0);
    send(CMD_ALLOC, 0, 0);
    write_reg(CFG_REGION_BYTES, 21'h1FFFFF);
    send(CMD_ALLOC, 20'hFFFFF, 0);
    send(CMD_ALLOC, 1048576 - 24, 0);
    send(CMD_FREE, 0, 8);
    // small region, many tiny blocks: fills both tables
    write_reg(CFG_REGION_BYTES, 2048);
    random_phase(150, 24);
    write_reg(CFG_FIT_POLICY, 1);
    random_phase(150, 40);
    write_reg(CFG_REGION_BYTES, 1048576);
    random_phase(120, 20000);
    write_reg(CFG_FIT_POLICY, 0);
    write_reg(CFG_REGION_BYTES, 600);
    random_phase(140, 30);
    write_reg(CFG_REGION_BYTES, 65536);
    random_phase(120, 3000);
    drain();
    $display("covered %0d requests: %0d granted or released, %0d rejected",
             sent, ok_count, reject_count);
    $display("both fit policies, regions from 0 to saturated, full tables and merges");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bwfa_pkg.sv
rtl/bwfa_ram.sv
rtl/bwfa_front.sv
rtl/bwfa_back.sv
rtl/best_worst_fit_segment_allocator.sv
dv/bwfa_checker.sv
dv/testbench.sv
